/* rtl/mmi_pkg.sv */
// ----------------------------------------------------------------------------
// mmi_pkg
// Shared constants, types and helpers for the modular matrix inverse block.
// ----------------------------------------------------------------------------
package mmi_pkg;

  localparam int MAX_DIM = 8;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int VAL_W   = 30;
  localparam int SIZE_W  = 4;

  localparam logic [VAL_W-1:0] PRIME      = 30'd1000000007;
  localparam logic [VAL_W-1:0] FERMAT_EXP = 30'd1000000005;

  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [IDX_W-1:0]  idx_t;

  typedef enum logic [4:0] {
    S_LOAD,
    S_INIT,
    S_PIV_RD,
    S_PIV_CHK,
    S_SW_RD,
    S_SW_W1,
    S_SW_W2,
    S_INV_STEP,
    S_INV_MR,
    S_INV_MB,
    S_SCL_RD,
    S_SCL_MW,
    S_SCL_WW,
    S_SCL_WI,
    S_ELM_FRD,
    S_ELM_F,
    S_ELM_RD,
    S_ELM_MW,
    S_ELM_WW,
    S_ELM_WI,
    S_OUT_RD,
    S_OUT_PUT,
    S_OUT_WAIT
  } state_t;

  function automatic val_t mod_sub(input val_t a, input val_t b);
    val_t r;
    if (a >= b) begin
      r = a - b;
    end else begin
      r = a + (PRIME - b);
    end
    return r;
  endfunction

endpackage

/* rtl/modular_matrix_inverse.sv */
// ----------------------------------------------------------------------------
// modular_matrix_inverse
// Gauss-Jordan inverse of an n x n matrix over GF(1000000007).
// Entries load one per cycle while in_valid is high; the elimination then
// runs on the shared serial multiplier (45 products per pivot inverse),
// row swaps go through S_SW_RD, S_SW_W1 and S_SW_W2 per column, and each
// result is held until out_ready. One matrix at a time.
// Reset: synchronous; size back to 1, load position and control cleared.
// ----------------------------------------------------------------------------
module modular_matrix_inverse (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write_en,
  input  logic [mmi_pkg::SIZE_W-1:0]    cfg_write_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [mmi_pkg::VAL_W-1:0]     element_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [mmi_pkg::VAL_W-1:0]     inverse_value,
  output logic                          singular,
  output logic                          last_of_run
);
  import mmi_pkg::*;

  state_t state, state_next;

  idx_t  nm1;
  idx_t  r, j, c;
  val_t  f, res, base, e, ta, tia;

  logic  w_we, i_we;
  addr_t w_waddr, i_waddr, rd_a, rd_b;
  val_t  w_wdata, i_wdata;
  val_t  wa, wb, ia, ib;

  logic  mul_start, mul_done;
  val_t  mul_a, mul_b, prod;

  val_t  vred;
  logic  in_acc, j_last, r_last, c_last;

  assign in_acc = in_valid && in_ready;
  assign j_last = (j == nm1);
  assign r_last = (r == nm1);
  assign c_last = (c == nm1);
  assign vred   = (element_value >= PRIME) ? element_value - PRIME : element_value;

  mmi_ram u_wram (
    .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
    .raddr_a(rd_a), .raddr_b(rd_b), .rdata_a(wa), .rdata_b(wb)
  );

  mmi_ram u_iram (
    .clk(clk), .we(i_we), .waddr(i_waddr), .wdata(i_wdata),
    .raddr_a(rd_a), .raddr_b(rd_b), .rdata_a(ia), .rdata_b(ib)
  );

  mmi_modmul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .product(prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = (state == S_LOAD);
    w_we       = 1'b0;
    i_we       = 1'b0;
    w_waddr    = {c, j};
    i_waddr    = {c, j};
    w_wdata    = wb;
    i_wdata    = ib;
    rd_a       = {c, j};
    rd_b       = {r, j};
    mul_start  = 1'b0;
    mul_a      = res;
    mul_b      = base;
    case (state)
      S_LOAD: begin
        w_we    = in_acc;
        w_waddr = {r, j};
        w_wdata = vred;
        if (in_acc && r_last && j_last) begin
          state_next = S_INIT;
        end
      end
      S_INIT: begin
        i_we    = 1'b1;
        i_waddr = {r, j};
        i_wdata = (r == j) ? val_t'(1) : '0;
        if (r_last && j_last) begin
          state_next = S_PIV_RD;
        end
      end
      S_PIV_RD: begin
        rd_a       = {r, c};
        state_next = S_PIV_CHK;
      end
      S_PIV_CHK: begin
        rd_a = {r, c};
        if (wa != '0) begin
          state_next = (r != c) ? S_SW_RD : S_INV_STEP;
        end else if (r_last) begin
          state_next = S_OUT_RD;
        end else begin
          state_next = S_PIV_RD;
        end
      end
      S_SW_RD: begin
        state_next = S_SW_W1;
      end
      S_SW_W1: begin
        w_we       = 1'b1;
        i_we       = 1'b1;
        state_next = S_SW_W2;
      end
      S_SW_W2: begin
        w_we       = 1'b1;
        i_we       = 1'b1;
        w_waddr    = {r, j};
        i_waddr    = {r, j};
        w_wdata    = ta;
        i_wdata    = tia;
        state_next = j_last ? S_INV_STEP : S_SW_RD;
      end
      S_INV_STEP: begin
        if (e == '0) begin
          state_next = S_SCL_RD;
        end else if (e[0]) begin
          mul_start  = 1'b1;
          state_next = S_INV_MR;
        end else begin
          mul_start  = 1'b1;
          mul_a      = base;
          state_next = S_INV_MB;
        end
      end
      S_INV_MR: begin
        if (mul_done) begin
          mul_start  = 1'b1;
          mul_a      = base;
          state_next = S_INV_MB;
        end
      end
      S_INV_MB: begin
        if (mul_done) begin
          state_next = S_INV_STEP;
        end
      end
      S_SCL_RD: begin
        state_next = S_SCL_MW;
      end
      S_SCL_MW: begin
        mul_start  = 1'b1;
        mul_a      = wa;
        mul_b      = res;
        state_next = S_SCL_WW;
      end
      S_SCL_WW: begin
        if (mul_done) begin
          w_we       = 1'b1;
          w_wdata    = prod;
          mul_start  = 1'b1;
          mul_a      = ia;
          mul_b      = res;
          state_next = S_SCL_WI;
        end
      end
      S_SCL_WI: begin
        if (mul_done) begin
          i_we       = 1'b1;
          i_wdata    = prod;
          state_next = j_last ? S_ELM_FRD : S_SCL_RD;
        end
      end
      S_ELM_FRD: begin
        rd_a = {r, c};
        if (r == c) begin
          if (r_last) begin
            state_next = c_last ? S_OUT_RD : S_PIV_RD;
          end
        end else begin
          state_next = S_ELM_F;
        end
      end
      S_ELM_F: begin
        rd_a = {r, c};
        if (wa == '0) begin
          if (r_last) begin
            state_next = c_last ? S_OUT_RD : S_PIV_RD;
          end else begin
            state_next = S_ELM_FRD;
          end
        end else begin
          state_next = S_ELM_RD;
        end
      end
      S_ELM_RD: begin
        state_next = S_ELM_MW;
      end
      S_ELM_MW: begin
        mul_start  = 1'b1;
        mul_a      = f;
        mul_b      = wa;
        state_next = S_ELM_WW;
      end
      S_ELM_WW: begin
        if (mul_done) begin
          w_we       = 1'b1;
          w_waddr    = {r, j};
          w_wdata    = mod_sub(wb, prod);
          mul_start  = 1'b1;
          mul_a      = f;
          mul_b      = ia;
          state_next = S_ELM_WI;
        end
      end
      S_ELM_WI: begin
        if (mul_done) begin
          i_we    = 1'b1;
          i_waddr = {r, j};
          i_wdata = mod_sub(ib, prod);
          if (!j_last) begin
            state_next = S_ELM_RD;
          end else if (r_last) begin
            state_next = c_last ? S_OUT_RD : S_PIV_RD;
          end else begin
            state_next = S_ELM_FRD;
          end
        end
      end
      S_OUT_RD: begin
        rd_a       = {r, j};
        state_next = S_OUT_PUT;
      end
      S_OUT_PUT: begin
        rd_a       = {r, j};
        state_next = S_OUT_WAIT;
      end
      S_OUT_WAIT: begin
        rd_a = {r, j};
        if (out_ready) begin
          state_next = last_of_run ? S_LOAD : S_OUT_RD;
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nm1       <= '0;
      r         <= '0;
      j         <= '0;
      c         <= '0;
      singular  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write_en) begin
        if (cfg_write_data == '0) begin
          nm1 <= '0;
        end else if (cfg_write_data > SIZE_W'(MAX_DIM)) begin
          nm1 <= idx_t'(MAX_DIM - 1);
        end else begin
          nm1 <= idx_t'(cfg_write_data - SIZE_W'(1));
        end
        r <= '0;
        j <= '0;
      end
      case (state)
        S_LOAD: begin
          if (in_acc && !cfg_write_en) begin
            j <= j_last ? '0 : j + idx_t'(1);
            if (j_last) begin
              r <= r_last ? '0 : r + idx_t'(1);
            end
          end
        end
        S_INIT: begin
          j <= j_last ? '0 : j + idx_t'(1);
          if (j_last) begin
            r <= r_last ? '0 : r + idx_t'(1);
          end
          c        <= '0;
          singular <= 1'b0;
        end
        S_PIV_CHK: begin
          j <= '0;
          if (wa != '0) begin
            base <= wa;
            res  <= val_t'(1);
            e    <= FERMAT_EXP;
          end else if (r_last) begin
            singular <= 1'b1;
            r        <= '0;
          end else begin
            r <= r + idx_t'(1);
          end
        end
        S_SW_W1: begin
          ta  <= wa;
          tia <= ia;
        end
        S_SW_W2: begin
          j <= j_last ? '0 : j + idx_t'(1);
        end
        S_INV_STEP: begin
          j <= '0;
        end
        S_INV_MR: begin
          if (mul_done) begin
            res <= prod;
          end
        end
        S_INV_MB: begin
          if (mul_done) begin
            base <= prod;
            e    <= e >> 1;
          end
        end
        S_SCL_WI: begin
          if (mul_done) begin
            j <= j_last ? '0 : j + idx_t'(1);
            if (j_last) begin
              r <= '0;
            end
          end
        end
        S_ELM_FRD: begin
          if (r == c) begin
            if (r_last) begin
              r <= c_last ? '0 : c + idx_t'(1);
              c <= c_last ? c : c + idx_t'(1);
              j <= '0;
            end else begin
              r <= r + idx_t'(1);
            end
          end
        end
        S_ELM_F: begin
          f <= wa;
          j <= '0;
          if (wa == '0) begin
            if (r_last) begin
              r <= c_last ? '0 : c + idx_t'(1);
              c <= c_last ? c : c + idx_t'(1);
            end else begin
              r <= r + idx_t'(1);
            end
          end
        end
        S_ELM_WI: begin
          if (mul_done) begin
            j <= j_last ? '0 : j + idx_t'(1);
            if (j_last) begin
              if (r_last) begin
                r <= c_last ? '0 : c + idx_t'(1);
                c <= c_last ? c : c + idx_t'(1);
              end else begin
                r <= r + idx_t'(1);
              end
            end
          end
        end
        S_OUT_PUT: begin
          out_valid     <= 1'b1;
          inverse_value <= singular ? '0 : ia;
          last_of_run   <= r_last && j_last;
        end
        S_OUT_WAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            j <= j_last ? '0 : j + idx_t'(1);
            if (j_last) begin
              r <= r_last ? '0 : r + idx_t'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && singular) |-> (inverse_value == '0))
    else $error("singular result carries a nonzero value");

  a_reduced: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (prod < PRIME))
    else $error("multiplier result not reduced");

  a_last_reload: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && last_of_run) |=> in_ready)
    else $error("block not ready after final result");

endmodule

/* rtl/mmi_ram.sv */
// ----------------------------------------------------------------------------
// mmi_ram
// Matrix store: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module mmi_ram (
  input  logic          clk,
  input  logic          we,
  input  mmi_pkg::addr_t waddr,
  input  mmi_pkg::val_t  wdata,
  input  mmi_pkg::addr_t raddr_a,
  input  mmi_pkg::addr_t raddr_b,
  output mmi_pkg::val_t  rdata_a,
  output mmi_pkg::val_t  rdata_b
);
  import mmi_pkg::*;

  val_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* rtl/mmi_modmul.sv */
// ----------------------------------------------------------------------------
// mmi_modmul
// Bit-serial modular multiplier, one bit of the multiplier per cycle.
// ----------------------------------------------------------------------------
module mmi_modmul (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  mmi_pkg::val_t  a,
  input  mmi_pkg::val_t  b,
  output logic          done,
  output mmi_pkg::val_t  product
);
  import mmi_pkg::*;

  localparam logic [31:0] P1 = {2'b00, PRIME};
  localparam logic [31:0] P2 = {1'b0, PRIME, 1'b0};

  logic        busy;
  logic [4:0]  cnt;
  val_t        ra;
  val_t        rb;
  logic [31:0] t;
  logic [31:0] t_red;

  always_comb begin
    t = {1'b0, product, 1'b0} + (rb[VAL_W-1] ? {2'b00, ra} : 32'd0);
    if (t >= P2) begin
      t_red = t - P2;
    end else if (t >= P1) begin
      t_red = t - P1;
    end else begin
      t_red = t;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        cnt     <= 5'(VAL_W - 1);
        ra      <= a;
        rb      <= b;
        product <= '0;
      end else if (busy) begin
        product <= t_red[VAL_W-1:0];
        rb      <= {rb[VAL_W-2:0], 1'b0};
        cnt     <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
